>>> rtl/core/scc_pkg.sv
// Package for the sliding cross-correlator: widths, word types, codes and sequencer states.
package scc_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int INDEX_BITS   = 6;
	localparam int TL_BITS      = 7;
	localparam int OUT_BITS     = 38;
	localparam int TAPS_DEFAULT = 64;
	localparam int TL_RESET     = 64;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic                          action;
		logic [INDEX_BITS-1:0]         index;
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          last;
	} req_word_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] corr_value;
		logic                       too_short;
		logic                       last_result;
	} rsp_word_t;

	typedef enum logic [1:0] {
		SCC_IDLE,
		SCC_RUN,
		SCC_DRAIN,
		SCC_DONE
	} scc_state_t;

endpackage

>>> rtl/core/sliding_cross_correlator.sv
// Sliding cross-correlator: template and delay-line memories with a shared multiply-accumulate.
// A load word writes one template coefficient; an index at or beyond TAPS is dropped. A sample
// word is written into a circular delay-line memory; when the run holds at least L samples
// (L is template_length clamped to 1..TAPS), one multiply-accumulate unit walks the window
// one tap per cycle, and the block takes no word until the result is registered. A sample that
// gives no result leaves the block idle; a run that ends too short gives a too_short result.
// The result waits in an output register, so the next word is taken while it is held.
// Outputs saturate at the 38-bit limits, which only larger parameter values can reach.
module sliding_cross_correlator #(
	parameter int TAPS = scc_pkg::TAPS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  scc_pkg::req_word_t            req_word,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output scc_pkg::rsp_word_t            rsp_word,
	input  logic                          cfg_we,
	input  logic [scc_pkg::TL_BITS-1:0]   cfg_wdata
);

	localparam int SB     = scc_pkg::SAMPLE_BITS;
	localparam int OW     = scc_pkg::OUT_BITS;
	localparam int AW     = $clog2(TAPS);
	localparam int LW     = $clog2(TAPS + 1);
	localparam int PW     = 2 * SB;
	localparam int NEED_W = PW + $clog2(TAPS);
	localparam int ACC_W  = (NEED_W > OW) ? NEED_W : OW;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OW - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (OW - 1)));

	logic signed [SB-1:0] tmpl_mem [TAPS];
	logic signed [SB-1:0] dly_mem  [TAPS];

	scc_pkg::scc_state_t state_q, state_d;

	logic [scc_pkg::TL_BITS-1:0] tl_q;
	logic [LW-1:0]               rc_q;
	logic [AW-1:0]               wptr_q;
	logic [AW-1:0]               ta_q;
	logic [AW-1:0]               da_q;
	logic                        last_q;
	logic                        ts_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        v_s1;
	logic                        v_s2;
	logic signed [SB-1:0]        tdat_s1;
	logic signed [SB-1:0]        ddat_s1;
	logic signed [PW-1:0]        prod_s2;
	logic                        rsp_valid_q;
	scc_pkg::rsp_word_t          rsp_word_q;

	logic          req_acc;
	logic          is_load;
	logic          load_ok;
	logic [AW-1:0] load_addr;
	logic [LW-1:0] len;
	logic [LW-1:0] rc_next;
	logic          full;
	logic [LW:0]   st_sum;
	logic [AW-1:0] start_addr;
	logic          issue;
	logic          issue_end;
	logic          rsp_free;
	logic          finish;
	logic signed [ACC_W-1:0] acc_sat;

	assign req_acc   = req_valid && !req_stall;
	assign is_load   = (req_word.action == scc_pkg::ACT_LOAD);
	assign load_ok   = (32'(req_word.index) < TAPS);
	assign load_addr = AW'(req_word.index);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (tl_q == '0) begin
			len = LW'(1);
		end else if (32'(tl_q) > TAPS) begin
			len = LW'(TAPS);
		end else begin
			len = LW'(tl_q);
		end
	end

	assign rc_next = (32'(rc_q) < TAPS) ? rc_q + LW'(1) : rc_q;
	assign full    = (rc_next >= len);
	assign st_sum  = (LW+1)'(wptr_q) + (LW+1)'(TAPS) - (LW+1)'(len - LW'(1));
	assign start_addr = (32'(st_sum) >= TAPS) ? AW'(st_sum - (LW+1)'(TAPS)) : AW'(st_sum);
	assign issue_end  = (LW'(ta_q) == len - LW'(1));

	always_comb begin
		if (acc_q > SAT_HI) begin
			acc_sat = SAT_HI;
		end else if (acc_q < SAT_LO) begin
			acc_sat = SAT_LO;
		end else begin
			acc_sat = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::SCC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		issue     = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			scc_pkg::SCC_IDLE: begin
				req_stall = 1'b0;
				if (req_acc && !is_load) begin
					if (full) begin
						state_d = scc_pkg::SCC_RUN;
					end else if (req_word.last) begin
						state_d = scc_pkg::SCC_DONE;
					end
				end
			end
			scc_pkg::SCC_RUN: begin
				issue = 1'b1;
				if (issue_end) begin
					state_d = scc_pkg::SCC_DRAIN;
				end
			end
			scc_pkg::SCC_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = scc_pkg::SCC_DONE;
				end
			end
			scc_pkg::SCC_DONE: begin
				if (rsp_free) begin
					finish  = 1'b1;
					state_d = scc_pkg::SCC_IDLE;
				end
			end
			default: begin
				state_d = scc_pkg::SCC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_acc && is_load && load_ok) begin
			tmpl_mem[load_addr] <= req_word.value;
		end
		if (req_acc && !is_load) begin
			dly_mem[wptr_q] <= req_word.value;
		end
		tdat_s1 <= tmpl_mem[ta_q];
		ddat_s1 <= dly_mem[da_q];
		prod_s2 <= tdat_s1 * ddat_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q        <= scc_pkg::TL_BITS'(scc_pkg::TL_RESET);
			rc_q        <= '0;
			wptr_q      <= '0;
			ta_q        <= '0;
			da_q        <= '0;
			last_q      <= 1'b0;
			ts_q        <= 1'b0;
			acc_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tl_q <= cfg_wdata;
			end
			if (req_acc && !is_load) begin
				rc_q   <= req_word.last ? '0 : rc_next;
				wptr_q <= (32'(wptr_q) == TAPS - 1) ? '0 : wptr_q + AW'(1);
				ta_q   <= '0;
				da_q   <= start_addr;
				last_q <= req_word.last;
				ts_q   <= !full;
				acc_q  <= '0;
			end
			if (issue) begin
				ta_q <= ta_q + AW'(1);
				da_q <= (32'(da_q) == TAPS - 1) ? '0 : da_q + AW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_word_q.corr_value  <= ts_q ? '0 : OW'(acc_sat);
			rsp_word_q.too_short   <= ts_q;
			rsp_word_q.last_result <= last_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

`ifndef NO_ASSERTIONS
	a_short_is_final_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.too_short |-> rsp_word.last_result && rsp_word.corr_value == '0)
		else $error("too_short word without final flag or with nonzero value");

	a_pipe_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == scc_pkg::SCC_RUN || state_q == scc_pkg::SCC_DRAIN))
		else $error("multiply-accumulate pipeline active outside a window walk");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scc_pkg::SCC_RUN |-> LW'(ta_q) < len && 32'(da_q) < TAPS)
		else $error("window read address out of range");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rc_q) <= TAPS)
		else $error("run count above TAPS");
`endif

endmodule
